// ===== design/tts_pkg.sv =====
// Shared types and constants for the timed task ring scheduler.
// No dependencies; every other design file but tts_ram refers to it by scoped names.
package tts_pkg;

    localparam int DEF_RING_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_POLL = 2'd0,
        OP_TICK = 2'd1,
        OP_ADD  = 2'd2,
        OP_SET  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2,
        ST_JUMP = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] delay;
        logic [15:0] id;
        logic [7:0]  handle;
        logic        user;
    } t_entry;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_POLL,
        CMD_RD,
        CMD_RB_WR,
        CMD_ADD_FIN,
        CMD_ST1_WR,
        CMD_ST2_WR,
        CMD_KCLR,
        CMD_DONE
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POLL,
        S_RB_RD,
        S_RB_WR,
        S_ADD_FIN,
        S_ST_RD,
        S_ST_WR,
        S_ST2_RD,
        S_ST2_WR
    } t_state;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic add_wrap;
        logic jump_bad;
        logic k_end;
        logic k2_end;
        logic need2;
    } t_dp_stat;

endpackage

// ===== design/timed_task_ring_scheduler.sv =====
// Top level of the timed task ring scheduler: controller plus datapath.
// Depends on tts_pkg, tts_ctrl, tts_datapath (and tts_ram below it).
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  command  | i_start, o_busy         | i_operation, i_task_handle, i_is_user_task,
//           |                         | i_delay_ms, i_new_time_ms
//  result   | o_done (one-cycle)      | o_fired, o_fired_handle, o_fired_id,
//           |                         | o_fired_start_ms, o_fired_delay_ms, o_status
//  config   | i_cfg_we                | i_cfg_wdata (user tasks enabled)
//
// A command transfers when i_start is high and o_busy is low; its result
// appears as an o_done pulse, after the steps below.
// Tick, poll on an empty ring and rejected set time: done straight from the accept.
// Poll: done after one registered RAM read.
// Add: accept then finish, with a rebase pass over the RAM first when the due time wraps.
// Set time: a read/write pass over all entries, plus a second pass over the entries before
// entry k when a wrap at entry k forces a rebase; the one-read, one-write-port RAM sets this.
// Reset clears counter, pointers and id; entry RAM holds garbage until written.
// The receiver cannot stall: each result is valid for exactly its o_done cycle.
module timed_task_ring_scheduler #(
    parameter int RING_DEPTH = tts_pkg::DEF_RING_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_task_handle,
    input  logic        i_is_user_task,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_new_time_ms,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_done,
    output logic        o_fired,
    output logic [7:0]  o_fired_handle,
    output logic [15:0] o_fired_id,
    output logic [31:0] o_fired_start_ms,
    output logic [31:0] o_fired_delay_ms,
    output logic [1:0]  o_status
);
    tts_pkg::t_cmd     cmd;
    tts_pkg::t_dp_stat stat;

    // sequence the ring passes
    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // hold time, ring and results
    tts_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_task_handle    (i_task_handle),
        .i_is_user_task   (i_is_user_task),
        .i_delay_ms       (i_delay_ms),
        .i_new_time_ms    (i_new_time_ms),
        .o_done           (o_done),
        .o_fired          (o_fired),
        .o_fired_handle   (o_fired_handle),
        .o_fired_id       (o_fired_id),
        .o_fired_start_ms (o_fired_start_ms),
        .o_fired_delay_ms (o_fired_delay_ms),
        .o_status         (o_status)
    );
endmodule

// ===== design/tts_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/tts_ctrl.sv =====
// Sequencer for the scheduler: walks the ring passes and issues datapath commands.
// Depends on tts_pkg.
module tts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tts_pkg::t_dp_stat i_stat,
    output tts_pkg::t_cmd     o_cmd,
    output logic              o_busy
);
    tts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = tts_pkg::CMD_NONE;
        unique case (r_state)
            tts_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd = tts_pkg::CMD_ACCEPT;
                    unique case (i_stat.op)
                        tts_pkg::OP_POLL: if (!i_stat.empty) n_state = tts_pkg::S_POLL;
                        tts_pkg::OP_TICK: n_state = tts_pkg::S_IDLE;
                        tts_pkg::OP_ADD:  n_state = i_stat.add_wrap ? tts_pkg::S_RB_RD
                                                                    : tts_pkg::S_ADD_FIN;
                        tts_pkg::OP_SET:  if (!i_stat.jump_bad) n_state = tts_pkg::S_ST_RD;
                        default:          n_state = tts_pkg::S_IDLE;
                    endcase
                end
            end
            tts_pkg::S_POLL: begin
                o_cmd   = tts_pkg::CMD_POLL;
                n_state = tts_pkg::S_IDLE;
            end
            tts_pkg::S_RB_RD: begin
                if (i_stat.k_end) begin
                    n_state = tts_pkg::S_ADD_FIN;
                end else begin
                    o_cmd   = tts_pkg::CMD_RD;
                    n_state = tts_pkg::S_RB_WR;
                end
            end
            tts_pkg::S_RB_WR: begin
                o_cmd   = tts_pkg::CMD_RB_WR;
                n_state = tts_pkg::S_RB_RD;
            end
            tts_pkg::S_ADD_FIN: begin
                o_cmd   = tts_pkg::CMD_ADD_FIN;
                n_state = tts_pkg::S_IDLE;
            end
            tts_pkg::S_ST_RD: begin
                if (!i_stat.k_end) begin
                    o_cmd   = tts_pkg::CMD_RD;
                    n_state = tts_pkg::S_ST_WR;
                end else if (i_stat.need2) begin
                    o_cmd   = tts_pkg::CMD_KCLR;
                    n_state = tts_pkg::S_ST2_RD;
                end else begin
                    o_cmd   = tts_pkg::CMD_DONE;
                    n_state = tts_pkg::S_IDLE;
                end
            end
            tts_pkg::S_ST_WR: begin
                o_cmd   = tts_pkg::CMD_ST1_WR;
                n_state = tts_pkg::S_ST_RD;
            end
            tts_pkg::S_ST2_RD: begin
                if (i_stat.k2_end) begin
                    o_cmd   = tts_pkg::CMD_DONE;
                    n_state = tts_pkg::S_IDLE;
                end else begin
                    o_cmd   = tts_pkg::CMD_RD;
                    n_state = tts_pkg::S_ST2_WR;
                end
            end
            tts_pkg::S_ST2_WR: begin
                o_cmd   = tts_pkg::CMD_ST2_WR;
                n_state = tts_pkg::S_ST2_RD;
            end
            default: n_state = tts_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != tts_pkg::S_IDLE);
endmodule

// ===== design/tts_datapath.sv =====
// Datapath: counter, ring pointers, entry RAM and result registers.
// Depends on tts_pkg and tts_ram.
module tts_datapath #(
    parameter int RING_DEPTH = tts_pkg::DEF_RING_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tts_pkg::t_cmd      i_cmd,
    output tts_pkg::t_dp_stat  o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_task_handle,
    input  logic               i_is_user_task,
    input  logic [31:0]        i_delay_ms,
    input  logic [31:0]        i_new_time_ms,
    output logic               o_done,
    output logic               o_fired,
    output logic [7:0]         o_fired_handle,
    output logic [15:0]        o_fired_id,
    output logic [31:0]        o_fired_start_ms,
    output logic [31:0]        o_fired_delay_ms,
    output logic [1:0]         o_status
);
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int EW = $bits(tts_pkg::t_entry);

    logic          r_uen;
    logic [31:0]   r_tc, n_tc;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_next_id, n_next_id;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_k0, n_k0;
    logic          r_rebased, n_rebased;
    logic          r_wrap, n_wrap;
    logic          r_pos, n_pos;
    logic [31:0]   r_sub, n_sub;
    logic [31:0]   r_off, n_off;
    logic [31:0]   r_due_new, n_due_new;
    logic [15:0]   r_id_new, n_id_new;
    logic [7:0]    r_handle, n_handle;
    logic          r_user, n_user;
    logic [31:0]   r_delay, n_delay;

    logic          r_done, n_done;
    logic          r_fired, n_fired;
    tts_pkg::t_entry r_res, n_res;
    tts_pkg::t_status r_status, n_status;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    tts_pkg::t_entry wdata, rdata;
    logic [EW-1:0] rdata_bits;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(RING_DEPTH)) s = s - SW'(RING_DEPTH);
        return s[AW-1:0];
    endfunction

    tts_ram #(.WIDTH(EW), .DEPTH(RING_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_bits)
    );
    assign rdata = tts_pkg::t_entry'(rdata_bits);

    // accept-time decode
    logic [32:0] add_sum, set_diff;
    logic        full;
    assign add_sum  = {1'b0, r_tc} + {1'b0, i_delay_ms};
    assign set_diff = {1'b0, i_new_time_ms} - {1'b0, r_tc};
    assign full     = (r_count == CW'(RING_DEPTH));

    assign o_stat.op       = tts_pkg::t_op'(i_operation);
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.add_wrap = add_sum[32];
    assign o_stat.jump_bad = (set_diff[32] != set_diff[31]);
    assign o_stat.k_end    = (r_k == r_count);
    assign o_stat.k2_end   = (r_k == r_k0);
    assign o_stat.need2    = r_rebased && (r_k0 != '0);

    // pass arithmetic on the entry just read
    logic [31:0] clamp_v, ttr;
    assign clamp_v = (rdata.due < r_sub) ? 32'd0 : rdata.due - r_sub;
    assign ttr     = rdata.due + r_off;

    assign raddr = (i_cmd == tts_pkg::CMD_ACCEPT) ? r_head : slot(r_head, r_k);

    logic allowed, due_ok;
    assign allowed = !rdata.user || r_uen;
    assign due_ok  = (rdata.due <= r_tc);

    always_comb begin
        n_tc = r_tc;  n_head = r_head;  n_count = r_count;  n_next_id = r_next_id;
        n_k = r_k;  n_k0 = r_k0;  n_rebased = r_rebased;  n_wrap = r_wrap;  n_pos = r_pos;
        n_sub = r_sub;  n_off = r_off;  n_due_new = r_due_new;  n_id_new = r_id_new;
        n_handle = r_handle;  n_user = r_user;  n_delay = r_delay;
        n_done = 1'b0;  n_fired = 1'b0;  n_res = '0;  n_status = tts_pkg::ST_OK;
        we = 1'b0;  waddr = slot(r_head, r_k);  wdata = rdata;
        unique case (i_cmd)
            tts_pkg::CMD_ACCEPT: begin
                unique case (tts_pkg::t_op'(i_operation))
                    tts_pkg::OP_POLL: begin
                        // nonempty: result comes after the RAM read
                        if (r_count == '0) begin
                            n_done   = 1'b1;
                            n_status = tts_pkg::ST_NONE;
                        end
                    end
                    tts_pkg::OP_TICK: begin
                        n_tc   = r_tc + 32'd1;
                        n_done = 1'b1;
                    end
                    tts_pkg::OP_ADD: begin
                        n_id_new  = r_next_id;
                        n_next_id = r_next_id + 16'd1;
                        n_wrap    = add_sum[32];
                        n_due_new = add_sum[32] ? i_delay_ms : add_sum[31:0];
                        n_sub     = r_tc;
                        n_k       = '0;
                        n_handle  = i_task_handle;
                        n_user    = i_is_user_task;
                        n_delay   = i_delay_ms;
                    end
                    tts_pkg::OP_SET: begin
                        if (set_diff[32] != set_diff[31]) begin
                            n_done   = 1'b1;
                            n_status = tts_pkg::ST_JUMP;
                        end else begin
                            n_tc      = i_new_time_ms;
                            n_sub     = i_new_time_ms;
                            n_off     = set_diff[31:0];
                            n_pos     = !set_diff[32] && (set_diff[31:0] != 32'd0);
                            n_k       = '0;
                            n_rebased = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            tts_pkg::CMD_POLL: begin
                n_done = 1'b1;
                n_head = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + AW'(1);
                if (due_ok && allowed) begin
                    n_fired = 1'b1;
                    n_res   = rdata;
                    n_count = r_count - CW'(1);
                end else begin
                    // rotate front to back
                    n_status = tts_pkg::ST_NONE;
                    waddr    = slot(r_head, r_count);
                    we       = (waddr != r_head);
                end
            end
            tts_pkg::CMD_RB_WR: begin
                we        = 1'b1;
                wdata.due = clamp_v;
                n_k       = r_k + CW'(1);
            end
            tts_pkg::CMD_ADD_FIN: begin
                n_done = 1'b1;
                if (r_wrap) n_tc = 32'd0;
                if (full) begin
                    n_status = tts_pkg::ST_FULL;
                end else begin
                    we           = 1'b1;
                    waddr        = slot(r_head, r_count);
                    wdata.due    = r_due_new;
                    wdata.delay  = r_delay;
                    wdata.id     = r_id_new;
                    wdata.handle = r_handle;
                    wdata.user   = r_user;
                    n_count      = r_count + CW'(1);
                end
            end
            tts_pkg::CMD_ST1_WR: begin
                we  = 1'b1;
                n_k = r_k + CW'(1);
                if (r_rebased) begin
                    wdata.due = clamp_v + r_off;
                end else if (r_pos && (ttr < r_sub)) begin
                    // first wrap: rebase; earlier entries get fixed in a second pass
                    wdata.due = clamp_v + r_off;
                    n_rebased = 1'b1;
                    n_k0      = r_k;
                    n_tc      = 32'd0;
                end else begin
                    wdata.due = ttr;
                end
            end
            tts_pkg::CMD_ST2_WR: begin
                we        = 1'b1;
                wdata.due = clamp_v;
                n_k       = r_k + CW'(1);
            end
            tts_pkg::CMD_KCLR: n_k = '0;
            tts_pkg::CMD_DONE: n_done = 1'b1;
            tts_pkg::CMD_RD, tts_pkg::CMD_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uen     <= 1'b1;
            r_tc      <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_next_id <= '0;
            r_done    <= 1'b0;
            r_k       <= '0;
            r_rebased <= 1'b0;
        end else begin
            if (i_cfg_we) r_uen <= i_cfg_wdata;
            r_tc      <= n_tc;
            r_head    <= n_head;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_done    <= n_done;
            r_k       <= n_k;
            r_rebased <= n_rebased;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k0 <= n_k0;  r_wrap <= n_wrap;  r_pos <= n_pos;  r_sub <= n_sub;  r_off <= n_off;
        r_due_new <= n_due_new;  r_id_new <= n_id_new;  r_handle <= n_handle;
        r_user <= n_user;  r_delay <= n_delay;
        r_fired <= n_fired;  r_res <= n_res;  r_status <= n_status;
    end

    assign o_done           = r_done;
    assign o_fired          = r_fired;
    assign o_fired_handle   = r_res.handle;
    assign o_fired_id       = r_res.id;
    assign o_fired_start_ms = r_res.due;
    assign o_fired_delay_ms = r_res.delay;
    assign o_status         = r_status;
endmodule
